### hw/rtl/cbde_pkg.sv
// Shared constants, types and step functions for the directional extrema block.
// No dependencies; imported by every module of the block.
package cbde_pkg;

  localparam int CW    = 32;      // coordinate width (signed Q16.16)
  localparam int DIRW  = 16;      // direction component width (signed Q1.14)
  localparam int IDXW  = 16;      // segment index width
  localparam int TW    = 16;      // fraction bits of t
  localparam int PW    = CW + DIRW;   // one projection product
  localparam int XW    = PW + 1;      // projected control point
  localparam int KW    = 54;          // coefficients a, b and c (signed)
  localparam int HW    = KW / 2;      // half of a magnitude for the split products
  localparam int DW    = 4 * HW;      // discriminant
  localparam int RW    = DW / 2;      // square root
  localparam int RMW   = RW + 3;      // square root remainder
  localparam int NW    = RW + 3;      // root numerator and denominator (signed)
  localparam int FIFO_DEPTH = 4;
  localparam int FPW   = $clog2(FIFO_DEPTH);

  localparam logic [1:0] KIND_CUBIC = 2'd2;

  localparam logic [1:0] REG_DIR_X = 2'd0;
  localparam logic [1:0] REG_DIR_Y = 2'd1;

  typedef struct packed {
    logic signed [KW-1:0] a;
    logic signed [KW-1:0] b;
    logic signed [KW-1:0] c;
    logic [IDXW-1:0]      idx;
    logic                 lin;
    logic                 quad;
  } side_t;

  typedef struct packed {
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    logic [DW-1:0]  d;
  } sq_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] den;
    logic [TW-1:0] q;
  } dv_t;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [TW-1:0]   t;
    logic            last;
  } res_t;

  // One digit of the integer square root: two bits of the radicand per step.
  function automatic sq_t sq_step(sq_t s);
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    sq_t o;
    cur   = {s.rem[RMW-3:0], s.d[DW-1:DW-2]};
    trial = {1'b0, s.root, 2'b01};
    o.d   = {s.d[DW-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  // One bit of a restoring division.
  function automatic dv_t dv_step(dv_t s);
    logic [NW-1:0] r2;
    dv_t o;
    r2    = {s.rem[NW-2:0], 1'b0};
    o.den = s.den;
    if (r2 >= s.den) begin
      o.rem = r2 - s.den;
      o.q   = {s.q[TW-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {s.q[TW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hw/rtl/cubic_bezier_directional_extrema.sv
// Top level of the directional extrema block: projection lanes, coefficient and
// discriminant stages, square root, two root lanes and the merging queue.
// Depends on cbde_pkg, cbde_proj, cbde_sqrt, cbde_root_lane and cbde_merge.
//
// Usage. A segment transaction is taken at a rising edge with start high and
// busy low. Only cubic segments produce results; others are dropped at entry.
// Each control point is projected onto (dir_x, dir_y), the coefficients a, b
// and c and the discriminant b*b - 4ac are formed, and the roots in (0,1) are
// turned into t = 1 - s as unsigned Q0.16. A segment gives zero, one or two
// result transactions; each shows on the out_ ports for one cycle with
// out_valid high, the second root of a pair in the cycle after the first, and
// out_is_last marks the final result of a segment.
// From acceptance to out_valid a result passes 2 projection stages, 5 coefficient
// and discriminant stages, 54 square root stages (one root digit per stage), one
// numerator stage, 17 divider stages (a load stage, then one quotient bit each),
// the queue write and the output register.
// Throughput is one segment per cycle while segments give at most one result
// each; the single output port drains one result per cycle, so a run of
// segments with two roots each fills the queue and is held back by busy. busy
// rises when the four-entry result queue cannot take two more results, and
// then the whole pipeline holds.
// The receiver cannot stall; results are never held back once issued.
// Reset clears all valid flags and the queue, and sets the direction to +x.
// Direction registers are written through cfg_; the user must write them only while the block is idle (not enforced).
module cubic_bezier_directional_extrema
  import cbde_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [DIRW-1:0]        cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_segment_kind,
  input  logic [IDXW-1:0]        in_segment_index,
  input  logic signed [CW-1:0]   in_p0_x,
  input  logic signed [CW-1:0]   in_p0_y,
  input  logic signed [CW-1:0]   in_p1_x,
  input  logic signed [CW-1:0]   in_p1_y,
  input  logic signed [CW-1:0]   in_p2_x,
  input  logic signed [CW-1:0]   in_p2_y,
  input  logic signed [CW-1:0]   in_p3_x,
  input  logic signed [CW-1:0]   in_p3_y,
  output logic                   out_valid,
  output logic [IDXW-1:0]        out_segment_index,
  output logic [TW-1:0]          out_t_value,
  output logic                   out_is_last
);

  // Direction registers.
  logic signed [DIRW-1:0] dir_x_r;
  logic signed [DIRW-1:0] dir_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r <= DIRW'(16384);
      dir_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIR_X: dir_x_r <= cfg_data;
        REG_DIR_Y: dir_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves only when the queue has room.
  logic en;
  logic take;

  assign busy = !en;
  assign take = start && en && (in_segment_kind == KIND_CUBIC);

  // Projection lanes, one per control point.
  logic signed [XW-1:0] x0, x1, x2, x3;

  cbde_proj u_proj0 (.clk, .en, .px(in_p0_x), .py(in_p0_y), .dx(dir_x_r), .dy(dir_y_r), .x(x0));
  cbde_proj u_proj1 (.clk, .en, .px(in_p1_x), .py(in_p1_y), .dx(dir_x_r), .dy(dir_y_r), .x(x1));
  cbde_proj u_proj2 (.clk, .en, .px(in_p2_x), .py(in_p2_y), .dx(dir_x_r), .dy(dir_y_r), .x(x2));
  cbde_proj u_proj3 (.clk, .en, .px(in_p3_x), .py(in_p3_y), .dx(dir_x_r), .dy(dir_y_r), .x(x3));

  // Valid and index travel beside the projection and coefficient stages.
  logic [6:0]      vld_r;
  logic [IDXW-1:0] idx1_r, idx2_r, idx3_r, idx4_r, idx5_r, idx6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], take};
    end
  end

  // Coefficients a, b, c.
  logic signed [KW-1:0] x0e, x1e, x2e, x3e;
  logic signed [KW-1:0] a3_r, b3_r, c3_r;

  assign x0e = KW'(x0);
  assign x1e = KW'(x1);
  assign x2e = KW'(x2);
  assign x3e = KW'(x3);

  // Magnitudes and sign facts.
  logic signed [KW-1:0] a4_r, b4_r, c4_r;
  logic [KW-1:0]        ma4_r, mb4_r, mc4_r;
  logic                 acneg4_r;

  // Split partial products of b*b and a*c.
  logic signed [KW-1:0] a5_r, b5_r, c5_r;
  logic                 acneg5_r;
  logic [2*HW-1:0]      bhh_r, bhl_r, bll_r, ahh_r, ahl_r, alh_r, all_r;

  // Summed products.
  logic signed [KW-1:0] a6_r, b6_r, c6_r;
  logic                 acneg6_r;
  logic [DW-1:0]        bb6_r, fac6_r;

  // Discriminant.
  logic [DW-1:0] d7_r;
  side_t         side7_r;
  logic          dneg;

  assign dneg = !acneg6_r && (fac6_r > bb6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= in_segment_index;
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      idx4_r <= idx3_r;
      idx5_r <= idx4_r;
      idx6_r <= idx5_r;

      a3_r <= x0e - ((x1e <<< 1) + x1e) + ((x2e <<< 1) + x2e) - x3e;
      b3_r <= (x1e - (x2e <<< 1) + x3e) <<< 1;
      c3_r <= x2e - x3e;

      a4_r     <= a3_r;
      b4_r     <= b3_r;
      c4_r     <= c3_r;
      ma4_r    <= (a3_r < 0) ? KW'(-a3_r) : KW'(a3_r);
      mb4_r    <= (b3_r < 0) ? KW'(-b3_r) : KW'(b3_r);
      mc4_r    <= (c3_r < 0) ? KW'(-c3_r) : KW'(c3_r);
      acneg4_r <= ((a3_r < 0) != (c3_r < 0)) && (c3_r != '0);

      a5_r     <= a4_r;
      b5_r     <= b4_r;
      c5_r     <= c4_r;
      acneg5_r <= acneg4_r;
      bhh_r    <= mb4_r[KW-1:HW] * mb4_r[KW-1:HW];
      bhl_r    <= mb4_r[KW-1:HW] * mb4_r[HW-1:0];
      bll_r    <= mb4_r[HW-1:0] * mb4_r[HW-1:0];
      ahh_r    <= ma4_r[KW-1:HW] * mc4_r[KW-1:HW];
      ahl_r    <= ma4_r[KW-1:HW] * mc4_r[HW-1:0];
      alh_r    <= ma4_r[HW-1:0] * mc4_r[KW-1:HW];
      all_r    <= ma4_r[HW-1:0] * mc4_r[HW-1:0];

      a6_r     <= a5_r;
      b6_r     <= b5_r;
      c6_r     <= c5_r;
      acneg6_r <= acneg5_r;
      bb6_r    <= (DW'(bhh_r) << (2*HW)) + (DW'(bhl_r) << (HW+1)) + DW'(bll_r);
      fac6_r   <= ((DW'(ahh_r) << (2*HW)) + ((DW'(ahl_r) + DW'(alh_r)) << HW)
                   + DW'(all_r)) << 2;

      d7_r         <= acneg6_r ? (bb6_r + fac6_r) : (bb6_r - fac6_r);
      side7_r.a    <= a6_r;
      side7_r.b    <= b6_r;
      side7_r.c    <= c6_r;
      side7_r.idx  <= idx6_r;
      side7_r.lin  <= (a6_r == '0) && (b6_r != '0);
      side7_r.quad <= (a6_r != '0) && !dneg;
    end
  end

  // Square root of the discriminant.
  logic          sq_vld;
  logic [RW-1:0] root;
  side_t         sq_side;

  cbde_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .vld_i (vld_r[6]),
    .d_i   (d7_r),
    .side_i(side7_r),
    .vld_o (sq_vld),
    .root_o(root),
    .side_o(sq_side)
  );

  // Numerators and denominators for the two root lanes; the linear case
  // uses lane 0 only.
  logic signed [NW-1:0] bn, an, cn, rn;
  logic signed [NW-1:0] n0_r, den0_r, n1_r, den1_r;
  logic                 l0_vld_r, l1_vld_r;
  logic [IDXW-1:0]      idx8_r;

  assign an = NW'(sq_side.a);
  assign bn = NW'(sq_side.b);
  assign cn = NW'(sq_side.c);
  assign rn = NW'({1'b0, root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_vld_r <= 1'b0;
      l1_vld_r <= 1'b0;
    end else if (en) begin
      l0_vld_r <= sq_vld && (sq_side.quad || sq_side.lin);
      l1_vld_r <= sq_vld && sq_side.quad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r   <= sq_side.quad ? (rn - bn) : -cn;
      den0_r <= sq_side.quad ? (an <<< 1) : bn;
      n1_r   <= -bn - rn;
      den1_r <= an <<< 1;
      idx8_r <= sq_side.idx;
    end
  end

  // Root lanes.
  logic            v0, v1;
  logic [TW-1:0]   q0, q1;
  logic [IDXW-1:0] tag0, tag1;

  cbde_root_lane u_lane0 (
    .clk, .rst_n, .en,
    .vld_i(l0_vld_r), .n_i(n0_r), .den_i(den0_r), .tag_i(idx8_r),
    .vld_o(v0), .q_o(q0), .tag_o(tag0)
  );

  cbde_root_lane u_lane1 (
    .clk, .rst_n, .en,
    .vld_i(l1_vld_r), .n_i(n1_r), .den_i(den1_r), .tag_i(idx8_r),
    .vld_o(v1), .q_o(q1), .tag_o(tag1)
  );

  // Merge and issue.
  res_t res;

  cbde_merge u_merge (
    .clk, .rst_n,
    .v0, .q0, .tag0,
    .v1, .q1, .tag1,
    .en,
    .out_vld(out_valid),
    .out_res(res)
  );

  assign out_segment_index = res.idx;
  assign out_t_value       = res.t;
  assign out_is_last       = res.last;

endmodule

### hw/rtl/cbde_proj.sv
// Projection lane: one control point projected onto the direction, two stages.
// Depends on cbde_pkg.
module cbde_proj
  import cbde_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CW-1:0]   px,
  input  logic signed [CW-1:0]   py,
  input  logic signed [DIRW-1:0] dx,
  input  logic signed [DIRW-1:0] dy,
  output logic signed [XW-1:0]   x
);

  logic signed [PW-1:0] px_r;
  logic signed [PW-1:0] py_r;
  logic signed [XW-1:0] x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= px * dx;
      py_r <= py * dy;
      x_r  <= XW'(px_r) + XW'(py_r);
    end
  end

  assign x = x_r;

endmodule

### hw/rtl/cbde_sqrt.sv
// Pipelined integer square root, one result digit per stage, with sideband.
// Depends on cbde_pkg.
module cbde_sqrt
  import cbde_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] d_i,
  input  side_t         side_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output side_t         side_o
);

  logic [RW-1:0] vld_r;
  sq_t           st_r   [RW];
  side_t         side_r [RW];
  sq_t           st_in;

  assign st_in = '{rem: '0, root: '0, d: d_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= sq_step(st_in);
      side_r[0] <= side_i;
      for (int s = 1; s < RW; s++) begin
        st_r[s]   <= sq_step(st_r[s-1]);
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = st_r[RW-1].root;
  assign side_o = side_r[RW-1];

endmodule

### hw/rtl/cbde_root_lane.sv
// Root lane: range check of n/den in (0,1) and a pipelined divider for 1 - n/den.
// Depends on cbde_pkg.
module cbde_root_lane
  import cbde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [NW-1:0] n_i,
  input  logic signed [NW-1:0] den_i,
  input  logic [IDXW-1:0]      tag_i,
  output logic                 vld_o,
  output logic [TW-1:0]        q_o,
  output logic [IDXW-1:0]      tag_o
);

  logic signed [NW-1:0] nn;
  logic signed [NW-1:0] dd;
  logic                 ok;
  logic [TW:0]          vld_r;
  dv_t                  st_r  [TW+1];
  logic [IDXW-1:0]      tag_r [TW+1];

  always_comb begin
    nn = (den_i < 0) ? -n_i : n_i;
    dd = (den_i < 0) ? -den_i : den_i;
    ok = vld_i && (dd != '0) && (nn > 0) && (nn < dd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TW-1:0], ok};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= '{rem: NW'(dd - nn), den: NW'(dd), q: '0};
      tag_r[0] <= tag_i;
      for (int s = 1; s <= TW; s++) begin
        st_r[s]  <= dv_step(st_r[s-1]);
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign vld_o = vld_r[TW];
  assign q_o   = st_r[TW].q;
  assign tag_o = tag_r[TW];

endmodule

### hw/rtl/cbde_merge.sv
// Merging stage: collects up to two roots per segment into a small queue and
// issues one result per cycle. Depends on cbde_pkg.
module cbde_merge
  import cbde_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            v0,
  input  logic [TW-1:0]   q0,
  input  logic [IDXW-1:0] tag0,
  input  logic            v1,
  input  logic [TW-1:0]   q1,
  input  logic [IDXW-1:0] tag1,
  output logic            en,
  output logic            out_vld,
  output res_t            out_res
);

  res_t           fifo_r [FIFO_DEPTH];
  logic [FPW-1:0] wr_r;
  logic [FPW-1:0] rd_r;
  logic [FPW:0]   cnt_r;
  logic [FPW:0]   cnt_nxt;
  logic           out_vld_r;
  res_t           out_res_r;
  logic [TW-1:0]  t0;
  logic [TW-1:0]  t1;
  logic [IDXW-1:0] tag;
  res_t           e0;
  res_t           e1;
  logic [1:0]     npush;
  logic           pop;

  assign en  = (cnt_r <= (FPW+1)'(FIFO_DEPTH - 2));
  assign pop = (cnt_r != '0);

  always_comb begin
    t0  = (q0 == '0) ? TW'(1) : q0;
    t1  = (q1 == '0) ? TW'(1) : q1;
    tag = v0 ? tag0 : tag1;
    if (v0) begin
      e0.idx  = tag;
      e0.t    = t0;
      e0.last = !v1;
    end else begin
      e0.idx  = tag;
      e0.t    = t1;
      e0.last = 1'b1;
    end
    e1.idx  = tag;
    e1.t    = t1;
    e1.last = 1'b1;
    npush = en ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
    cnt_nxt = cnt_r + (FPW+1)'(npush) - (FPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r      <= '0;
      rd_r      <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      wr_r      <= wr_r + FPW'(npush);
      rd_r      <= rd_r + FPW'(pop);
      cnt_r     <= cnt_nxt;
      out_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      fifo_r[wr_r] <= e0;
    end
    if (npush == 2'd2) begin
      fifo_r[wr_r + FPW'(1)] <= e1;
    end
    if (pop) begin
      out_res_r <= fifo_r[rd_r];
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

endmodule

### tb/tb_cubic_bezier_directional_extrema.sv
// Self-checking testbench for cubic_bezier_directional_extrema.
// Depends on cbde_pkg and the block's RTL; drives segments, predicts extrema, checks results.
`timescale 1ns / 1ps
module tb_cubic_bezier_directional_extrema;
  import cbde_pkg::*;

  typedef struct {
    logic [1:0]           kind;
    logic [IDXW-1:0]      idx;
    logic signed [CW-1:0] p[8];  // p0_x, p0_y, p1_x, ... p3_y
  } segment_t;

  typedef struct {
    logic [IDXW-1:0] idx;
    logic [TW-1:0]   t;
    logic            last;
  } extremum_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [DIRW-1:0]      cfg_data;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_segment_kind;
  logic [IDXW-1:0]      in_segment_index;
  logic signed [CW-1:0] in_p[8];
  logic                 out_valid;
  logic [IDXW-1:0]      out_segment_index;
  logic [TW-1:0]        out_t_value;
  logic                 out_is_last;

  segment_t  pending_segments[$];
  extremum_t expected_extrema[$];
  logic signed [DIRW-1:0] dir_x_model;
  logic signed [DIRW-1:0] dir_y_model;
  int  sender_idle_pct;
  int  errors;
  int  quiet_cycles;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  cubic_bezier_directional_extrema u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_segment_kind(in_segment_kind), .in_segment_index(in_segment_index),
    .in_p0_x(in_p[0]), .in_p0_y(in_p[1]), .in_p1_x(in_p[2]), .in_p1_y(in_p[3]),
    .in_p2_x(in_p[4]), .in_p2_y(in_p[5]), .in_p3_x(in_p[6]), .in_p3_y(in_p[7]),
    .out_valid(out_valid), .out_segment_index(out_segment_index),
    .out_t_value(out_t_value), .out_is_last(out_is_last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Turns one root s = n/den into t = 1 - s in Q0.16, or -1 when s lies
  // outside the open interval (0,1). A t that floors to zero is raised to one.
  function automatic int t_from_root(logic signed [127:0] n, logic signed [127:0] den);
    logic signed [127:0] q;
    if (den < 0) begin
      n = -n;
      den = -den;
    end
    if (den == 0 || n <= 0 || n >= den) return -1;
    q = ((den - n) <<< TW) / den;
    if (q == 0) q = 1;
    return int'(q);
  endfunction

  // Works out the extrema of one segment along the current direction and
  // queues them in the order +root, then -root.
  function automatic void predict_extrema(segment_t s);
    logic signed [127:0] x[4];
    logic signed [127:0] dx, dy, px, py, a, b, c, disc, r, cand;
    int t[2];
    int n_found;
    extremum_t e;
    n_found = 0;
    if (s.kind != KIND_CUBIC) return;
    dx = dir_x_model;
    dy = dir_y_model;
    for (int i = 0; i < 4; i++) begin
      px = s.p[2*i];
      py = s.p[2*i+1];
      x[i] = px * dx + py * dy;
    end
    a = x[0] - 3 * x[1] + 3 * x[2] - x[3];
    b = 2 * (x[1] - 2 * x[2] + x[3]);
    c = x[2] - x[3];
    if (a == 0) begin
      if (b != 0) begin
        t[0] = t_from_root(-c, b);
        if (t[0] >= 0) n_found = 1;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) return;
      r = 0;
      for (int i = 55; i >= 0; i--) begin
        cand = r | (128'sd1 <<< i);
        if (cand * cand <= disc) r = cand;
      end
      t[0] = t_from_root(-b + r, 2 * a);
      t[1] = t_from_root(-b - r, 2 * a);
      if (t[0] < 0) begin
        t[0] = t[1];
        t[1] = -1;
      end
      n_found = (t[0] >= 0) + (t[1] >= 0);
    end
    for (int k = 0; k < n_found; k++) begin
      e.idx  = s.idx;
      e.t    = t[k][TW-1:0];
      e.last = (k == n_found - 1);
      expected_extrema = {expected_extrema, e};
    end
  endfunction

  // Driver: presents the oldest pending segment at the falling edge, leaving
  // random gaps according to the current phase. The item is popped by the
  // acceptance logic below, so a held transaction simply stays on the ports.
  always @(negedge clk) begin
    if (rst_n && pending_segments.size() > 0 &&
        $urandom_range(99) >= sender_idle_pct) begin
      start            <= 1'b1;
      in_segment_kind  <= pending_segments[0].kind;
      in_segment_index <= pending_segments[0].idx;
      for (int i = 0; i < 8; i++) in_p[i] <= pending_segments[0].p[i];
    end else begin
      start <= 1'b0;
    end
  end

  // Acceptance, result checking and the watchdog, all sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        predict_extrema(pending_segments.pop_front());
      end
      if (out_valid) begin
        if (expected_extrema.size() == 0) begin
          $display("%0t: unexpected result idx=%0d t=%0d last=%0d", $time,
                   out_segment_index, out_t_value, out_is_last);
          errors <= errors + 1;
        end else begin
          extremum_t e;
          e = expected_extrema.pop_front();
          if (out_segment_index !== e.idx || out_t_value !== e.t ||
              out_is_last !== e.last) begin
            $display("%0t: mismatch expected idx=%0d t=%0d last=%0d, got idx=%0d t=%0d last=%0d",
                     $time, e.idx, e.t, e.last, out_segment_index, out_t_value,
                     out_is_last);
            errors <= errors + 1;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return CW'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
    if (sel < 8) return CW'($urandom);
    return CW'($signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200);
  endfunction

  task automatic add_segment(logic [1:0] kind, logic signed [CW-1:0] x0,
                             logic signed [CW-1:0] x1, logic signed [CW-1:0] x2,
                             logic signed [CW-1:0] x3);
    segment_t s;
    s.kind = kind;
    s.idx  = IDXW'($urandom);
    s.p[0] = x0; s.p[2] = x1; s.p[4] = x2; s.p[6] = x3;
    s.p[1] = rand_coord(); s.p[3] = rand_coord();
    s.p[5] = rand_coord(); s.p[7] = rand_coord();
    pending_segments = {pending_segments, s};
  endtask

  task automatic add_random_segments(int count);
    segment_t s;
    for (int n = 0; n < count; n++) begin
      // Mostly cubics so that the arithmetic sees real work; other kinds
      // are kept as noise.
      s.kind = ($urandom_range(9) < 8) ? KIND_CUBIC : 2'($urandom_range(3));
      s.idx  = IDXW'($urandom);
      for (int i = 0; i < 8; i++) s.p[i] = rand_coord();
      pending_segments = {pending_segments, s};
    end
  endtask

  // Waits until the block has nothing left in flight, including segments
  // that produce no result and so leave no trace in the expectation queue.
  task automatic wait_idle();
    while (pending_segments.size() > 0 || expected_extrema.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(logic signed [DIRW-1:0] dx, logic signed [DIRW-1:0] dy);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_DIR_X; cfg_data <= dx;
    @(negedge clk);
    cfg_index <= REG_DIR_Y; cfg_data <= dy;
    @(negedge clk);
    cfg_we <= 1'b0;
    dir_x_model = dx;
    dir_y_model = dy;
  endtask

  initial begin
    int idle_by_phase[5];
    logic signed [DIRW-1:0] dx_by_phase[5];
    logic signed [DIRW-1:0] dy_by_phase[5];
    idle_by_phase = '{14, 14, 52, 52, 0};
    dx_by_phase   = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd7};
    dy_by_phase   = '{16'sd0, 16'sd16384, -16'sd16384, -16'sd11585, 16'sd16384};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = REG_DIR_X; cfg_data = '0;
    start = 1'b0; in_segment_kind = '0; in_segment_index = '0;
    for (int i = 0; i < 8; i++) in_p[i] = '0;
    errors = 0; quiet_cycles = 0;
    sender_idle_pct = 14;
    dir_x_model = 16'sd16384;
    dir_y_model = 16'sd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed segments under the reset direction (+x).
    add_segment(2'd0, 1, 5, -7, 9);
    add_segment(2'd1, 1, 5, -7, 9);
    add_segment(2'd3, 1, 5, -7, 9);
    add_segment(KIND_CUBIC, 0, 0, 0, 0);                 // a and b both zero
    add_segment(KIND_CUBIC, 0, 1, 1, 0);                 // linear root at one half
    add_segment(KIND_CUBIC, 0, 0, 1, 3);                 // linear root at the end
    add_segment(KIND_CUBIC, 1, 0, 1, 0);                 // double root at one half
    add_segment(KIND_CUBIC, 0, 1, 2, 4);                 // negative discriminant case
    add_segment(KIND_CUBIC, 0, 3, -3, 0);                // two roots inside
    add_segment(KIND_CUBIC, -1572861, -1572862, -1048575, 0);  // t floors to zero
    add_segment(KIND_CUBIC, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                32'sh8000_0000);
    add_segment(KIND_CUBIC, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                32'sh7fff_ffff);
    add_segment(KIND_CUBIC, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                32'sh7fff_ffff);
    add_segment(KIND_CUBIC, -1, 0, 0, 1);
    begin
      segment_t s;
      s.kind = KIND_CUBIC; s.idx = 16'hffff;
      for (int i = 0; i < 8; i++) s.p[i] = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      pending_segments = {pending_segments, s};
      s.idx = 16'h0000;
      for (int i = 0; i < 8; i++) s.p[i] = (i % 2 == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      pending_segments = {pending_segments, s};
    end
    wait_idle();

    // Random phases, each under its own direction, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      write_direction(dx_by_phase[ph], dy_by_phase[ph]);
      sender_idle_pct = idle_by_phase[ph];
      add_random_segments(290);
      wait_idle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
